/* hw/rtl/sha1d_pkg.sv */
package sha1d_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_ADD,
		S_OUT
	} sha1d_state_t;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned BLOCK_W   = 512;
	localparam int unsigned COUNT_W   = 61;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned ROUND_W   = 7;
	localparam int unsigned NUM_CHAIN = 5;

	localparam logic [POS_W-1:0]   BLK_LAST   = 6'd63;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
	localparam logic [ROUND_W-1:0] ROUND_20   = 7'd20;
	localparam logic [ROUND_W-1:0] ROUND_40   = 7'd40;
	localparam logic [ROUND_W-1:0] ROUND_60   = 7'd60;

	localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

	localparam logic [WORD_W-1:0] INIT_CHAIN [NUM_CHAIN] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

endpackage

/* hw/rtl/sha1_digest_top.sv */
// Channel | Signals                                   | Direction
// input   | in_valid, in_stall, byte_value/valid, last | byte stream into the block
// output  | out_valid, out_stall, digest_word0..4      | one digest per message
//
// While idle, the block takes a data byte or an idle transaction. Each 64th byte of the block
// starts the compression: 80 rounds on one shared round adder, then a step that folds
// the result into the chaining words by adding the five working variables.
// A transaction with last also shifts in the pad bytes one per cycle (up to 72 over
// two blocks) with one or two compressions, then holds the digest until it is taken.
// The input is stalled for all of that time. Reset loads the initial chaining words
// and clears the byte count; the block, working-variable and digest registers need no reset.
module sha1_digest_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word0,
	output logic [31:0] digest_word1,
	output logic [31:0] digest_word2,
	output logic [31:0] digest_word3,
	output logic [31:0] digest_word4
);
	import sha1d_pkg::*;

	sha1d_state_t state_q, state_d;

	// The message block is a 512-bit shift line. Bytes enter at the low end; during the
	// rounds it shifts by a word, so the top word is always the current schedule word.
	logic [BLOCK_W-1:0] blk_q;
	logic [WORD_W-1:0]  chain_q [NUM_CHAIN];
	logic [WORD_W-1:0]  vars_q  [NUM_CHAIN];
	logic [WORD_W-1:0]  dig_q   [NUM_CHAIN];
	logic [COUNT_W-1:0] cnt_q;
	logic [POS_W-1:0]   pos_q;
	logic [ROUND_W-1:0] round_q;
	logic               pad_pend_q;
	logic               pad_first_q;
	logic               len_ok_q;
	logic               done_q;

	logic               accept;
	logic               shift_byte;
	logic [BYTE_W-1:0]  byte_in;
	logic [BYTE_W-1:0]  pad_byte;
	logic [63:0]        len_bits;
	logic [63:0]        len_sh;
	logic [WORD_W-1:0]  w0, w2, w8, w13, w_mix, w_new;
	logic [WORD_W-1:0]  f_val, k_val, t_val;

	assign accept = in_valid && !in_stall;

	// Length field: bit count, sent most significant byte first at positions 56..63.
	assign len_bits = {cnt_q, 3'b000};
	assign len_sh   = len_bits << {pos_q[2:0], 3'b000};

	always_comb begin
		priority if (pad_first_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_ok_q && (pos_q[5:3] == 3'b111)) begin
			pad_byte = len_sh[63:56];
		end else begin
			pad_byte = '0;
		end
	end

	assign shift_byte = (accept && byte_valid) || (state_q == S_PAD);
	assign byte_in    = (state_q == S_PAD) ? pad_byte : byte_value;

	// Schedule taps and the rolled word W[t+16].
	assign w0    = blk_q[BLOCK_W-1 -: WORD_W];
	assign w2    = blk_q[BLOCK_W-1-2*WORD_W -: WORD_W];
	assign w8    = blk_q[BLOCK_W-1-8*WORD_W -: WORD_W];
	assign w13   = blk_q[BLOCK_W-1-13*WORD_W -: WORD_W];
	assign w_mix = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

	// Round function and constant by round group.
	always_comb begin
		priority if (round_q < ROUND_20) begin
			f_val = (vars_q[1] & vars_q[2]) | (~vars_q[1] & vars_q[3]);
			k_val = K_0;
		end else if (round_q < ROUND_40) begin
			f_val = vars_q[1] ^ vars_q[2] ^ vars_q[3];
			k_val = K_1;
		end else if (round_q < ROUND_60) begin
			f_val = (vars_q[1] & vars_q[2]) | (vars_q[1] & vars_q[3])
				| (vars_q[2] & vars_q[3]);
			k_val = K_2;
		end else begin
			f_val = vars_q[1] ^ vars_q[2] ^ vars_q[3];
			k_val = K_3;
		end
	end

	assign t_val = {vars_q[0][WORD_W-6:0], vars_q[0][WORD_W-1 -: 5]}
		+ f_val + vars_q[4] + k_val + w0;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (byte_valid && (pos_q == BLK_LAST)) begin
						state_d = S_ROUND;
					end else if (last) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				if (pos_q == BLK_LAST) begin
					state_d = S_ROUND;
				end
			end
			S_ROUND: begin
				if (round_q == ROUND_LAST) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				if (done_q) begin
					state_d = S_OUT;
				end else if (pad_pend_q) begin
					state_d = S_PAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE:  in_stall  = 1'b0;
			S_OUT:   out_valid = 1'b1;
			default: in_stall  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			round_q     <= '0;
			pad_pend_q  <= 1'b0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			done_q      <= 1'b0;
			chain_q     <= INIT_CHAIN;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pad_pend_q  <= last;
				pad_first_q <= last;
				len_ok_q    <= 1'b0;
				done_q      <= 1'b0;
				if (byte_valid) begin
					cnt_q <= cnt_q + COUNT_W'(1);
				end
			end
			if (shift_byte) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (state_q == S_PAD) begin
				if (pad_first_q) begin
					pad_first_q <= 1'b0;
					// The length fits after the pad byte only if it lands before byte 56.
					len_ok_q    <= (pos_q[5:3] != 3'b111);
				end else if (len_ok_q && (pos_q == BLK_LAST)) begin
					done_q <= 1'b1;
				end
			end
			if (state_q == S_ROUND) begin
				round_q <= (round_q == ROUND_LAST) ? '0 : round_q + ROUND_W'(1);
			end
			if (state_q == S_ADD) begin
				if (done_q) begin
					chain_q    <= INIT_CHAIN;
					cnt_q      <= '0;
					pad_pend_q <= 1'b0;
				end else begin
					for (int i = 0; i < NUM_CHAIN; i++) begin
						chain_q[i] <= chain_q[i] + vars_q[i];
					end
					if (pad_pend_q) begin
						len_ok_q <= 1'b1;
					end
				end
			end
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (shift_byte) begin
			blk_q <= {blk_q[BLOCK_W-BYTE_W-1:0], byte_in};
			if (pos_q == BLK_LAST) begin
				vars_q <= chain_q;
			end
		end else if (state_q == S_ROUND) begin
			blk_q     <= {blk_q[BLOCK_W-WORD_W-1:0], w_new};
			vars_q[4] <= vars_q[3];
			vars_q[3] <= vars_q[2];
			vars_q[2] <= {vars_q[1][1:0], vars_q[1][WORD_W-1:2]};
			vars_q[1] <= vars_q[0];
			vars_q[0] <= t_val;
		end
		if ((state_q == S_ADD) && done_q) begin
			for (int i = 0; i < NUM_CHAIN; i++) begin
				dig_q[i] <= chain_q[i] + vars_q[i];
			end
		end
	end

	assign digest_word0 = dig_q[0];
	assign digest_word1 = dig_q[1];
	assign digest_word2 = dig_q[2];
	assign digest_word3 = dig_q[3];
	assign digest_word4 = dig_q[4];

endmodule
